FILE: hw/rtl/bat_pkg.sv
`default_nettype none

package bat_pkg;

  localparam int LOG_POOL_UNITS_DEF = 10;

  localparam int CODE_W   = 5;
  localparam int SIZE_W   = 11;
  localparam int OFF_W    = 10;
  localparam int STATUS_W = 2;
  localparam int EXP_W    = 4;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTHING = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Exponent of the smallest power of two that covers the size; a size of zero counts as one.
  function automatic logic [EXP_W-1:0] size_exp(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    logic [EXP_W-1:0]  k;
    m = (size == '0) ? '0 : size - SIZE_W'(1);
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) k = EXP_W'(i + 1);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bat_ram.sv
`default_nettype none

module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/buddy_allocator_tree.sv
`default_nettype none

// Channel   Ports                                         Handshake
// request   operation, request_size, free_offset          taken when start && !busy
// result    block_offset, status                          one cycle, marked by done
//
// After reset the tree memory is filled with the free codes, one node per cycle, for all
// 2^(LOG_POOL_UNITS+1)-1 nodes; busy stays high meanwhile.
// An allocate checks the root, descends to the level of 2^k units, marks that node taken and
// rewrites its ancestors; a refused one ends at the root check. A free climbs to the taken
// node, then rewrites the ancestors, one tree level per cycle of the single memory read port.
// A new word may be started in the cycle that shows done. Results cannot be held off.

module buddy_allocator_tree
  import bat_pkg::*;
#(
  parameter int LOG_POOL_UNITS = LOG_POOL_UNITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation,
  input  wire logic [SIZE_W-1:0]   request_size,
  input  wire logic [OFF_W-1:0]    free_offset,
  output logic                     done,
  output logic [OFF_W-1:0]         block_offset,
  output logic [STATUS_W-1:0]      status
);

  localparam int AW    = LOG_POOL_UNITS + 1;
  localparam int NODES = (2 ** AW) - 1;
  localparam int WW    = OFF_W + AW;
  localparam int EW    = LOG_POOL_UNITS + OFF_W;

  localparam logic [CODE_W-1:0] ROOT_CODE = CODE_W'(LOG_POOL_UNITS + 1);
  localparam logic [CODE_W-1:0] LOG_CODE  = CODE_W'(LOG_POOL_UNITS);
  localparam logic [AW-1:0]     LEAF_BASE = AW'((2 ** LOG_POOL_UNITS) - 1);
  localparam logic [AW-1:0]     LAST_NODE = AW'(NODES - 1);
  localparam logic [WW-1:0]     POOL_SIZE = WW'(2 ** LOG_POOL_UNITS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_CHECK = 3'd2;
  localparam logic [2:0] S_A_DOWN  = 3'd3;
  localparam logic [2:0] S_A_MARK  = 3'd4;
  localparam logic [2:0] S_F_CLIMB = 3'd5;
  localparam logic [2:0] S_UP      = 3'd6;

  function automatic logic [AW-1:0] left_of(input logic [AW-1:0] n);
    return {n[AW-2:0], 1'b1};
  endfunction

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] n);
    logic [AW-1:0] m;
    m = n - AW'(1);
    return m >> 1;
  endfunction

  function automatic logic [AW-1:0] buddy_of(input logic [AW-1:0] n);
    return n[0] ? n + AW'(1) : n - AW'(1);
  endfunction

  logic [2:0]          state, state_next;
  logic                op, op_next;
  logic [EXP_W-1:0]    kexp, kexp_next;
  logic [AW-1:0]       idx, idx_next;
  logic [CODE_W-1:0]   lvl, lvl_next;
  logic [CODE_W-1:0]   code, code_next;
  logic                oor, oor_next;
  logic [OFF_W-1:0]    res_offset, res_offset_next;
  logic                done_next;
  logic [OFF_W-1:0]    block_offset_next;
  logic [STATUS_W-1:0] status_next;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [CODE_W-1:0]   wr_data;
  logic [AW-1:0]       rd_addr;
  logic [CODE_W-1:0]   rd_data;

  logic [CODE_W-1:0]   kexp_code;
  logic [CODE_W-1:0]   need_code;
  logic [WW-1:0]       off_wide;
  logic [AW-1:0]       leaf_addr;
  logic [AW-1:0]       chosen;
  logic [AW-1:0]       parent;
  logic [CODE_W-1:0]   up_code;
  logic [AW-1:0]       shifted;
  logic [EW-1:0]       off_ext;

  assign busy      = (state != S_IDLE);
  assign kexp_code = CODE_W'(kexp);
  assign need_code = kexp_code + CODE_W'(1);
  assign off_wide  = WW'(free_offset);
  assign leaf_addr = LEAF_BASE + off_wide[AW-1:0];
  assign chosen    = (rd_data >= need_code) ? left_of(idx) : left_of(idx) + AW'(1);
  assign parent    = parent_of(idx);
  // The node at idx holds the block being marked; (idx+1) << k less the pool size is its offset.
  assign shifted   = (idx + AW'(1)) << kexp;
  assign off_ext   = EW'(shifted[LOG_POOL_UNITS-1:0]);

  // Parent code on the way up: the larger child code, but a free merges two fully free buddies into one block.
  always_comb begin
    if (op == OP_FREE && code == rd_data && code == lvl) begin
      up_code = lvl + CODE_W'(1);
    end else begin
      up_code = (code > rd_data) ? code : rd_data;
    end
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    kexp_next         = kexp;
    idx_next          = idx;
    lvl_next          = lvl;
    code_next         = code;
    oor_next          = oor;
    res_offset_next   = res_offset;
    done_next         = 1'b0;
    block_offset_next = block_offset;
    status_next       = status;
    wr_en             = 1'b0;
    wr_addr           = idx;
    wr_data           = code;
    rd_addr           = '0;

    unique case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        idx_next = idx + AW'(1);
        if (((idx + AW'(2)) & (idx + AW'(1))) == '0) code_next = code - CODE_W'(1);
        if (idx == LAST_NODE) state_next = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          op_next         = operation;
          kexp_next       = size_exp(request_size);
          res_offset_next = '0;
          if (operation == OP_FREE) begin
            rd_addr    = leaf_addr;
            idx_next   = leaf_addr;
            lvl_next   = CODE_W'(1);
            oor_next   = (off_wide >= POOL_SIZE);
            state_next = S_F_CLIMB;
          end else begin
            idx_next   = '0;
            state_next = S_A_CHECK;
          end
        end
      end

      S_A_CHECK: begin
        if (kexp_code > LOG_CODE || rd_data < need_code) begin
          done_next         = 1'b1;
          status_next       = STAT_NO_ROOM;
          block_offset_next = '0;
          state_next        = S_IDLE;
        end else if (kexp_code == LOG_CODE) begin
          state_next = S_A_MARK;
        end else begin
          rd_addr    = left_of(idx);
          lvl_next   = LOG_CODE - CODE_W'(1);
          state_next = S_A_DOWN;
        end
      end

      S_A_DOWN: begin
        idx_next = chosen;
        if (lvl == kexp_code) begin
          state_next = S_A_MARK;
        end else begin
          rd_addr  = left_of(chosen);
          lvl_next = lvl - CODE_W'(1);
        end
      end

      S_A_MARK: begin
        wr_en           = 1'b1;
        wr_data         = '0;
        code_next       = '0;
        res_offset_next = off_ext[OFF_W-1:0];
        if (idx == '0) begin
          done_next         = 1'b1;
          status_next       = STAT_DONE;
          block_offset_next = off_ext[OFF_W-1:0];
          state_next        = S_IDLE;
        end else begin
          rd_addr    = buddy_of(idx);
          state_next = S_UP;
        end
      end

      S_F_CLIMB: begin
        if (oor || (rd_data != '0 && idx == '0)) begin
          done_next         = 1'b1;
          status_next       = STAT_NOTHING;
          block_offset_next = '0;
          state_next        = S_IDLE;
        end else if (rd_data != '0) begin
          idx_next = parent;
          rd_addr  = parent;
          lvl_next = lvl + CODE_W'(1);
        end else begin
          wr_en     = 1'b1;
          wr_data   = lvl;
          code_next = lvl;
          if (idx == '0) begin
            done_next         = 1'b1;
            status_next       = STAT_DONE;
            block_offset_next = '0;
            state_next        = S_IDLE;
          end else begin
            rd_addr    = buddy_of(idx);
            state_next = S_UP;
          end
        end
      end

      S_UP: begin
        wr_en     = 1'b1;
        wr_addr   = parent;
        wr_data   = up_code;
        idx_next  = parent;
        code_next = up_code;
        lvl_next  = lvl + CODE_W'(1);
        if (parent == '0) begin
          done_next         = 1'b1;
          status_next       = STAT_DONE;
          block_offset_next = res_offset;
          state_next        = S_IDLE;
        end else begin
          rd_addr = buddy_of(parent);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      code  <= ROOT_CODE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      code  <= code_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    kexp         <= kexp_next;
    lvl          <= lvl_next;
    oor          <= oor_next;
    res_offset   <= res_offset_next;
    block_offset <= block_offset_next;
    status       <= status_next;
  end

  bat_ram #(
    .WIDTH(CODE_W),
    .DEPTH(NODES)
  ) u_tree (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // A result is shown only once the sequencer is back to waiting for a word.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("tree written while idle");

  // While the walk goes on, it never reads the node that it writes in the same cycle.
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != S_CLEAR && state_next != S_IDLE) |-> (rd_addr != wr_addr))
    else $error("read and write of the same node in one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_DONE || status == STAT_NO_ROOM || status == STAT_NOTHING))
    else $error("undefined status code");

endmodule

`default_nettype wire

FILE: verif/buddy_allocator_tree_tb.sv
`default_nettype none

module buddy_allocator_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bat_pkg::*;

  localparam int LOG        = LOG_POOL_UNITS_DEF;
  localparam int POOL       = 1 << LOG;
  localparam int NODES      = 2 * POOL - 1;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 2 * LOG + 8;

  typedef struct packed {
    logic [OFF_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                operation = OP_ALLOC;
  logic [SIZE_W-1:0]   request_size = '0;
  logic [OFF_W-1:0]    free_offset = '0;
  logic                busy;
  logic                done;
  logic [OFF_W-1:0]    block_offset;
  logic [STATUS_W-1:0] status;

  // Shadow of the tree: per node, 0 when nothing is free below, else log2 of the largest
  // free block plus one.
  logic [CODE_W-1:0] free_code [NODES];
  grant_t            grants_due [$];
  int                held_base [$];
  int                held_len [$];
  int                held_units = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                burst_mode = 1'b0;

  buddy_allocator_tree #(
    .LOG_POOL_UNITS(LOG)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .request_size(request_size),
    .free_offset(free_offset),
    .done(done),
    .block_offset(block_offset),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic grant_t tree_allocate(logic [SIZE_W-1:0] size);
    int     need;
    int     k;
    int     idx;
    grant_t g;
    need = (size == '0) ? 1 : int'(size);
    k = 0;
    while (k <= LOG && (1 << k) < need) k++;
    g.offset = '0;
    g.status = STAT_NO_ROOM;
    if (k > LOG || int'(free_code[0]) < k + 1) return g;
    idx = 0;
    for (int lvl = LOG; lvl > k; lvl--) begin
      idx = (int'(free_code[2*idx+1]) >= k + 1) ? 2*idx + 1 : 2*idx + 2;
    end
    free_code[idx] = '0;
    g.offset = OFF_W'(((idx + 1) << k) - POOL);
    while (idx != 0) begin
      idx = (idx - 1) >> 1;
      free_code[idx] = (free_code[2*idx+1] > free_code[2*idx+2]) ?
                       free_code[2*idx+1] : free_code[2*idx+2];
    end
    g.status = STAT_DONE;
    return g;
  endfunction

  function automatic grant_t tree_release(logic [OFF_W-1:0] off);
    int                idx;
    int                lvl;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    grant_t            g;
    g.offset = '0;
    g.status = STAT_NOTHING;
    if (int'(off) >= POOL) return g;
    idx = int'(off) + POOL - 1;
    lvl = 1;
    // Climb to the lowest node marked as taken; reaching the root means nothing is held here.
    while (free_code[idx] != '0) begin
      if (idx == 0) return g;
      idx = (idx - 1) >> 1;
      lvl++;
    end
    free_code[idx] = CODE_W'(lvl);
    while (idx != 0) begin
      idx = (idx - 1) >> 1;
      lvl++;
      a = free_code[2*idx+1];
      b = free_code[2*idx+2];
      if (a == b && int'(a) == lvl - 1) free_code[idx] = CODE_W'(lvl);
      else free_code[idx] = (a > b) ? a : b;
    end
    g.status = STAT_DONE;
    return g;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        note_mismatch("unexpected result word, status", -1, int'(status));
      end else begin
        want = grants_due.pop_front();
        if (block_offset !== want.offset) begin
          note_mismatch("block_offset", int'(want.offset), int'(block_offset));
        end
        if (status !== want.status) note_mismatch("status", int'(want.status), int'(status));
      end
    end
  end

  // Sends one request word and books the predicted grant at the edge that takes it.
  task automatic issue_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [OFF_W-1:0] off);
    int     gap;
    int     len;
    grant_t g;
    @(negedge clk);
    if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    request_size <= size;
    free_offset  <= off;
    do @(posedge clk); while (busy);
    if (op == OP_ALLOC) begin
      g = tree_allocate(size);
      if (g.status == STAT_DONE) begin
        len = 1;
        while (len < int'(size)) len <<= 1;
        held_base.push_back(int'(g.offset));
        held_len.push_back(len);
        held_units += len;
      end
    end else begin
      g = tree_release(off);
      if (g.status == STAT_DONE) begin
        for (int i = 0; i < held_base.size(); i++) begin
          if (int'(off) >= held_base[i] && int'(off) < held_base[i] + held_len[i]) begin
            held_units -= held_len[i];
            held_base.delete(i);
            held_len.delete(i);
            break;
          end
        end
      end
    end
    grants_due.push_back(g);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    wait (grants_due.size() == 0);
  endtask

  task automatic free_random_held();
    int i;
    i = $urandom_range(0, held_base.size() - 1);
    issue_request(OP_FREE, SIZE_W'($urandom), 
                  OFF_W'(held_base[i] + $urandom_range(0, held_len[i] - 1)));
  endtask

  task automatic test_corner_requests();
    issue_request(OP_ALLOC, 11'd0, 10'd0);
    issue_request(OP_ALLOC, 11'd1024, 10'd1023);
    issue_request(OP_ALLOC, 11'd2047, 10'd0);
    issue_request(OP_ALLOC, 11'd1025, 10'd0);
    issue_request(OP_FREE, 11'd0, 10'd0);
    issue_request(OP_FREE, 11'd2047, 10'd0);
    issue_request(OP_ALLOC, 11'd1024, 10'd0);
    issue_request(OP_ALLOC, 11'd1, 10'd0);
    // An offset in the middle of the whole-pool block releases that block.
    issue_request(OP_FREE, 11'd0, 10'd517);
    issue_request(OP_ALLOC, 11'd3, 10'd0);
    issue_request(OP_ALLOC, 11'd512, 10'd0);
    issue_request(OP_ALLOC, 11'd256, 10'd0);
    issue_request(OP_ALLOC, 11'd255, 10'd0);
    issue_request(OP_ALLOC, 11'd128, 10'd0);
    issue_request(OP_ALLOC, 11'd1, 10'd0);
    issue_request(OP_FREE, 11'd0, 10'd1023);
    issue_request(OP_FREE, 11'd0, 10'd1023);
    issue_request(OP_FREE, 11'd0, 10'd6);
    issue_request(OP_FREE, 11'd0, 10'd2);
    issue_request(OP_FREE, 11'd0, 10'd4);
    issue_request(OP_ALLOC, 11'd1023, 10'd0);
    issue_request(OP_FREE, 11'd0, 10'd300);
    issue_request(OP_FREE, 11'd0, 10'd130);
    issue_request(OP_ALLOC, 11'd1024, 10'd0);
    issue_request(OP_FREE, 11'd0, 10'd1023);
  endtask

  task automatic test_fill_and_merge();
    for (int i = 0; i < 64; i++) issue_request(OP_ALLOC, SIZE_W'($urandom_range(9, 16)), 
                                               OFF_W'($urandom));
    issue_request(OP_ALLOC, 11'd1, OFF_W'($urandom));
    while (held_base.size() != 0) free_random_held();
  endtask

  task automatic test_random_traffic(input int count);
    int                r;
    int                s;
    logic [SIZE_W-1:0] size;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (s < 60) size = SIZE_W'($urandom_range(0, 8));
      else if (s < 85) size = SIZE_W'($urandom_range(9, 64));
      else if (s < 97) size = SIZE_W'($urandom_range(65, 256));
      else size = SIZE_W'($urandom_range(257, 1024));
      if (held_base.size() == 0 || (r < 50 && held_units < 900)) begin
        issue_request(OP_ALLOC, size, OFF_W'($urandom));
      end else if (r < 88) begin
        free_random_held();
      end else if (r < 94) begin
        issue_request(OP_FREE, SIZE_W'($urandom), OFF_W'($urandom));
      end else begin
        issue_request(OP_ALLOC, SIZE_W'($urandom_range(1024, 2047)), OFF_W'($urandom));
      end
      if (n == count / 2) wait_idle();
    end
  endtask

  initial begin
    for (int d = 0; d <= LOG; d++) begin
      for (int i = (1 << d) - 1; i <= (2 << d) - 2; i++) free_code[i] = CODE_W'(LOG - d + 1);
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_corner_requests();
    wait_idle();
    test_fill_and_merge();
    wait_idle();
    test_random_traffic(1750);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
